// ===== rtl/ilbp_pkg.sv =====
// Shared types and constants for the ILBP texture histogram.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ilbp_pkg;

   localparam int BINS                = 512;
   localparam int BIN_IDX_WIDTH       = 9;
   localparam int PATTERN_BITS        = 9;
   localparam int WINDOW_PIXELS       = 9;
   localparam int OUT_COUNT_WIDTH     = 20;
   localparam int COUNT_WIDTH_DEFAULT = 20;
   localparam int PIXEL_WIDTH_DEFAULT = 8;
   localparam int QUEUE_DEPTH         = 4;
   localparam int QUEUE_PTR_WIDTH     = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH     = $clog2(QUEUE_DEPTH + 1);

   localparam logic CMD_ACCUMULATE = 1'b0;
   localparam logic CMD_READ       = 1'b1;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } state_type;

   // One classified item, passed from the front through the queue to the back.
   typedef struct packed {
      logic                     is_read;
      logic [PATTERN_BITS-1:0]  code;
      logic [BIN_IDX_WIDTH-1:0] bin_idx;
   } item_type;

endpackage

`default_nettype wire

// ===== rtl/ilbp_front.sv =====
// Front end: takes request beats, forms the 9-bit pattern and its
// rotation-minimal code over two stages. Depends on ilbp_pkg.
`default_nettype none

module ilbp_front #(
   parameter int PIXEL_WIDTH = ilbp_pkg::PIXEL_WIDTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_cmd,
   input  wire logic [PIXEL_WIDTH-1:0]                req_pixel_0,
   input  wire logic [PIXEL_WIDTH-1:0]                req_pixel_1,
   input  wire logic [PIXEL_WIDTH-1:0]                req_pixel_2,
   input  wire logic [PIXEL_WIDTH-1:0]                req_pixel_3,
   input  wire logic [PIXEL_WIDTH-1:0]                req_pixel_4,
   input  wire logic [PIXEL_WIDTH-1:0]                req_pixel_5,
   input  wire logic [PIXEL_WIDTH-1:0]                req_pixel_6,
   input  wire logic [PIXEL_WIDTH-1:0]                req_pixel_7,
   input  wire logic [PIXEL_WIDTH-1:0]                req_pixel_8,
   input  wire logic [ilbp_pkg::BIN_IDX_WIDTH-1:0]    req_bin_index,
   input  wire logic                                  clearing,
   input  wire logic [ilbp_pkg::QUEUE_CNT_WIDTH-1:0]  q_count,
   output logic                                       q_push,
   output ilbp_pkg::item_type                         q_item
);

   localparam int PB    = ilbp_pkg::PATTERN_BITS;
   localparam int NPIX  = ilbp_pkg::WINDOW_PIXELS;
   localparam int SUM_W = PIXEL_WIDTH + 4;
   localparam int OCC_W = ilbp_pkg::QUEUE_CNT_WIDTH + 1;

   function automatic logic [PB-1:0] min_rotation(input logic [PB-1:0] pat);
      logic [PB-1:0] rot;
      logic [PB-1:0] best;
      begin
         rot  = pat;
         best = pat;
         for (int k = 0; k < PB - 1; k++) begin
            rot = {rot[0], rot[PB-1:1]};
            if (rot < best) begin
               best = rot;
            end
         end
         return best;
      end
   endfunction

   logic [PIXEL_WIDTH-1:0]             px [NPIX];
   logic [SUM_W-1:0]                   sum;
   logic [PB-1:0]                      pattern;
   logic                               accept;
   logic [OCC_W-1:0]                   occupancy;

   logic                               s1_valid_ff, s1_valid_in;
   logic                               s1_is_read_ff;
   logic [PB-1:0]                      s1_pattern_ff;
   logic [ilbp_pkg::BIN_IDX_WIDTH-1:0] s1_idx_ff;
   logic                               s2_valid_ff, s2_valid_in;
   ilbp_pkg::item_type                 s2_item_ff, s2_item_in;

   assign px[0] = req_pixel_0;
   assign px[1] = req_pixel_1;
   assign px[2] = req_pixel_2;
   assign px[3] = req_pixel_3;
   assign px[4] = req_pixel_4;
   assign px[5] = req_pixel_5;
   assign px[6] = req_pixel_6;
   assign px[7] = req_pixel_7;
   assign px[8] = req_pixel_8;

   // Hold off new beats while clearing, or unless every item in flight is sure of a queue slot.
   assign occupancy = OCC_W'(q_count) + OCC_W'(s1_valid_ff) + OCC_W'(s2_valid_ff);
   assign req_stall = clearing || (occupancy >= OCC_W'(ilbp_pkg::QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      sum = '0;
      for (int i = 0; i < NPIX; i++) begin
         sum = sum + SUM_W'(px[i]);
      end
      for (int i = 0; i < NPIX; i++) begin
         pattern[PB-1-i] = (sum >= ((SUM_W'(px[i]) << 3) + SUM_W'(px[i])));
      end
   end

   always_comb begin
      s1_valid_in = accept;
      s2_valid_in = s1_valid_ff;
      if (s1_is_read_ff == ilbp_pkg::CMD_READ) begin
         s2_item_in.is_read = 1'b1;
         s2_item_in.code    = '0;
         s2_item_in.bin_idx = s1_idx_ff;
      end else begin
         s2_item_in.is_read = 1'b0;
         s2_item_in.code    = min_rotation(s1_pattern_ff);
         s2_item_in.bin_idx = min_rotation(s1_pattern_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_is_read_ff <= req_cmd;
         s1_pattern_ff <= pattern;
         s1_idx_ff     <= req_bin_index;
      end
      s2_item_ff <= s2_item_in;
   end

   assign q_push = s2_valid_ff;
   assign q_item = s2_item_ff;

endmodule

`default_nettype wire

// ===== rtl/ilbp_queue.sv =====
// Short FIFO of classified items between front and back.
// Depends on ilbp_pkg.
`default_nettype none

module ilbp_queue (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 push,
   input  wire ilbp_pkg::item_type                   push_item,
   input  wire logic                                 pop,
   output ilbp_pkg::item_type                        head,
   output logic                                      not_empty,
   output logic [ilbp_pkg::QUEUE_CNT_WIDTH-1:0]      count
);

   localparam int PW = ilbp_pkg::QUEUE_PTR_WIDTH;
   localparam int CW = ilbp_pkg::QUEUE_CNT_WIDTH;

   ilbp_pkg::item_type entry_ff [ilbp_pkg::QUEUE_DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule

`default_nettype wire

// ===== rtl/ilbp_back.sv =====
// Back end: histogram memory, read-modify-write with forwarding,
// post-reset clearing pass and result register. Depends on ilbp_pkg.
`default_nettype none

module ilbp_back #(
   parameter int COUNT_WIDTH = ilbp_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  q_valid,
   input  wire ilbp_pkg::item_type                    q_head,
   output logic                                       q_pop,
   output logic                                       clearing,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [ilbp_pkg::PATTERN_BITS-1:0]          rsp_pattern_code,
   output logic [ilbp_pkg::OUT_COUNT_WIDTH-1:0]       rsp_bin_count
);

   localparam int IW    = ilbp_pkg::BIN_IDX_WIDTH;
   localparam int OUT_W = ilbp_pkg::OUT_COUNT_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [IW-1:0]          LAST_BIN  = IW'(ilbp_pkg::BINS - 1);

   logic [COUNT_WIDTH-1:0] hist_mem [ilbp_pkg::BINS];

   ilbp_pkg::state_type    state_ff, state_in;
   logic [IW-1:0]          clr_idx_ff, clr_idx_in;

   logic                   b_valid_ff, b_valid_in;
   ilbp_pkg::item_type     b_item_ff;
   logic [COUNT_WIDTH-1:0] rdata_ff;

   logic                   wr_valid_ff, wr_valid_in;
   logic [IW-1:0]          wr_idx_ff;
   logic [COUNT_WIDTH-1:0] wr_val_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ilbp_pkg::PATTERN_BITS-1:0] rsp_code_ff;
   logic [OUT_W-1:0]       rsp_count_ff;

   logic                   b_fire;
   logic [COUNT_WIDTH-1:0] cur_count;
   logic [COUNT_WIDTH-1:0] new_count;
   logic [COUNT_WIDTH-1:0] result_count;
   logic                   mem_we;
   logic [IW-1:0]          mem_waddr;
   logic [COUNT_WIDTH-1:0] mem_wdata;

   // Clearing pass sequencer.
   always_comb begin
      state_in   = state_ff;
      clr_idx_in = clr_idx_ff;
      clearing   = 1'b0;
      case (state_ff)
         ilbp_pkg::ST_CLEAR: begin
            clearing   = 1'b1;
            clr_idx_in = clr_idx_ff + IW'(1);
            if (clr_idx_ff == LAST_BIN) begin
               state_in = ilbp_pkg::ST_RUN;
            end
         end
         ilbp_pkg::ST_RUN: begin
            clearing = 1'b0;
         end
         default: begin
            state_in = ilbp_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ilbp_pkg::ST_CLEAR;
         clr_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   // Update stage: forward the previous write when it hit the same bin.
   always_comb begin
      b_fire = b_valid_ff && (!rsp_valid_ff || !rsp_stall);
      q_pop  = q_valid && !clearing && (!b_valid_ff || b_fire);

      if (wr_valid_ff && (wr_idx_ff == b_item_ff.bin_idx)) begin
         cur_count = wr_val_ff;
      end else begin
         cur_count = rdata_ff;
      end

      if (b_item_ff.is_read) begin
         new_count    = '0;
         result_count = cur_count;
      end else begin
         new_count    = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_WIDTH'(1);
         result_count = new_count;
      end

      if (clearing) begin
         mem_we    = 1'b1;
         mem_waddr = clr_idx_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = b_fire;
         mem_waddr = b_item_ff.bin_idx;
         mem_wdata = new_count;
      end

      b_valid_in   = q_pop || (b_valid_ff && !b_fire);
      wr_valid_in  = wr_valid_ff || b_fire;
      rsp_valid_in = b_fire || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_waddr] <= mem_wdata;
      end
      if (q_pop) begin
         rdata_ff <= hist_mem[q_head.bin_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         wr_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         wr_valid_ff  <= wr_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         b_item_ff <= q_head;
      end
      if (b_fire) begin
         wr_idx_ff    <= b_item_ff.bin_idx;
         wr_val_ff    <= new_count;
         rsp_code_ff  <= b_item_ff.code;
         rsp_count_ff <= OUT_W'(result_count);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pattern_code = rsp_code_ff;
   assign rsp_bin_count    = rsp_count_ff;

endmodule

`default_nettype wire

// ===== rtl/ilbp_texture_histogram_top.sv =====
// ILBP texture histogram, top level. A request beat passes through the two front
// stages, the queue, the update stage and the result register.
// Throughput: one beat per cycle while neither the clearing pass nor rsp_stall holds
// the flow, set by the histogram read-modify-write with one read and one write of
// the bin memory each cycle and a forward of the last write. Reset: synchronous; a
// clearing pass then zeroes all 512 bins, one per cycle, and req_stall stays high
// until it is done. Depends on ilbp_pkg, front, queue and back modules.
`default_nettype none

module ilbp_texture_histogram_top #(
   parameter int COUNT_WIDTH = ilbp_pkg::COUNT_WIDTH_DEFAULT,
   parameter int PIXEL_WIDTH = ilbp_pkg::PIXEL_WIDTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_cmd,
   input  wire logic [PIXEL_WIDTH-1:0]             req_pixel_0,
   input  wire logic [PIXEL_WIDTH-1:0]             req_pixel_1,
   input  wire logic [PIXEL_WIDTH-1:0]             req_pixel_2,
   input  wire logic [PIXEL_WIDTH-1:0]             req_pixel_3,
   input  wire logic [PIXEL_WIDTH-1:0]             req_pixel_4,
   input  wire logic [PIXEL_WIDTH-1:0]             req_pixel_5,
   input  wire logic [PIXEL_WIDTH-1:0]             req_pixel_6,
   input  wire logic [PIXEL_WIDTH-1:0]             req_pixel_7,
   input  wire logic [PIXEL_WIDTH-1:0]             req_pixel_8,
   input  wire logic [ilbp_pkg::BIN_IDX_WIDTH-1:0] req_bin_index,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [ilbp_pkg::PATTERN_BITS-1:0]       rsp_pattern_code,
   output logic [ilbp_pkg::OUT_COUNT_WIDTH-1:0]    rsp_bin_count
);

   // Front -> queue -> back. The front never stalls internally: it only takes
   // a beat when the queue is guaranteed room for everything in flight, so
   // both front stages simply advance every cycle.
   logic                                   q_push;
   ilbp_pkg::item_type                     q_push_item;
   logic                                   q_pop;
   ilbp_pkg::item_type                     q_head;
   logic                                   q_not_empty;
   logic [ilbp_pkg::QUEUE_CNT_WIDTH-1:0]   q_count;
   logic                                   clearing;

   // Stage 1 forms the window mean compare, stage 2 picks the smallest
   // rotation and tags read beats with their bin.
   ilbp_front #(
      .PIXEL_WIDTH (PIXEL_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_pixel_0   (req_pixel_0),
      .req_pixel_1   (req_pixel_1),
      .req_pixel_2   (req_pixel_2),
      .req_pixel_3   (req_pixel_3),
      .req_pixel_4   (req_pixel_4),
      .req_pixel_5   (req_pixel_5),
      .req_pixel_6   (req_pixel_6),
      .req_pixel_7   (req_pixel_7),
      .req_pixel_8   (req_pixel_8),
      .req_bin_index (req_bin_index),
      .clearing      (clearing),
      .q_count       (q_count),
      .q_push        (q_push),
      .q_item        (q_push_item)
   );

   // Decouple the classify pipeline from result back-pressure.
   ilbp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .pop       (q_pop),
      .head      (q_head),
      .not_empty (q_not_empty),
      .count     (q_count)
   );

   // Read the bin on pop, update and write it from the update stage once the result register can take it. A one-entry
   // forward of the last write covers back-to-back beats on the same bin.
   ilbp_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_not_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .clearing         (clearing),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pattern_code (rsp_pattern_code),
      .rsp_bin_count    (rsp_bin_count)
   );

   // The credit check must keep the queue from overflowing.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_pop) |-> (q_count < ilbp_pkg::QUEUE_CNT_WIDTH'(ilbp_pkg::QUEUE_DEPTH)))
      else $error("queue push while full");

   // Pop only from a non-empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty)
      else $error("queue pop while empty");

   // No beat may be taken at the request port or leave the queue while the bins are being cleared.
   a_idle_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> (!q_pop && !(req_valid && !req_stall)))
      else $error("traffic during clearing pass");

   // A read beat returns a zero pattern code.
   a_read_code_zero: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_head.is_read) |-> (q_head.code == '0))
      else $error("read item carries a pattern code");

endmodule

`default_nettype wire
